// ===== rtl/apq_pkg.sv =====
package apq_pkg;

    localparam int unsigned CAPACITY_DEF = 64;

    localparam int unsigned OP_W   = 2;
    localparam int unsigned TIME_W = 20;
    localparam int unsigned ID_W   = 64;
    localparam int unsigned SEV_W  = 20;
    localparam int unsigned RATE_W = 24;
    localparam int unsigned PROD_W = RATE_W + TIME_W;
    localparam int unsigned KEY_W  = 48;
    localparam int unsigned STAT_W = 2;

    localparam int unsigned IN_W  = 112;
    localparam int unsigned OUT_W = 72;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SERVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_SERVED = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_CMP   = 3'd1,
        CMD_INS   = 3'd2,
        CMD_POP   = 3'd3,
        CMD_MATCH = 3'd4,
        CMD_PACK  = 3'd5
    } t_cmd;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [ID_W-1:0]   id;
    } t_slot;

    typedef struct packed {
        t_cmd              cmd;
        logic [KEY_W-1:0]  key;
        logic [ID_W-1:0]   id;
    } t_cell_ctl;

    // true when (ka, ia) is served before (kb, ib); keys are two's complement
    function automatic logic ahead_of(logic [KEY_W-1:0] ka, logic [ID_W-1:0] ia,
                                      logic [KEY_W-1:0] kb, logic [ID_W-1:0] ib);
        if (ka != kb) begin
            return $signed(ka) > $signed(kb);
        end
        return ia < ib;
    endfunction

endpackage

// ===== rtl/apq_cell.sv =====
module apq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  apq_pkg::t_cell_ctl i_ctl,
    input  apq_pkg::t_slot     i_prev,
    input  logic               i_prev_ahead,
    input  apq_pkg::t_slot     i_next,
    output apq_pkg::t_slot     o_slot,
    output logic               o_ahead,
    output logic               o_eq
);

    apq_pkg::t_slot r_slot;
    apq_pkg::t_slot n_slot;
    logic           r_ahead;
    logic           n_ahead;
    logic           r_eq;
    logic           n_eq;

    always_comb begin
        n_slot  = r_slot;
        n_ahead = r_ahead;
        n_eq    = r_eq;
        unique case (i_ctl.cmd)
            apq_pkg::CMD_CMP: begin
                n_ahead = !r_slot.valid ||
                          apq_pkg::ahead_of(i_ctl.key, i_ctl.id, r_slot.key, r_slot.id);
                n_eq    = r_slot.valid && (r_slot.key == i_ctl.key) &&
                          (r_slot.id == i_ctl.id);
            end
            apq_pkg::CMD_INS: begin
                if (r_ahead) begin
                    if (i_prev_ahead) begin
                        n_slot = i_prev;
                    end else begin
                        n_slot.valid = 1'b1;
                        n_slot.key   = i_ctl.key;
                        n_slot.id    = i_ctl.id;
                    end
                end
            end
            apq_pkg::CMD_POP: begin
                n_slot = i_next;
            end
            apq_pkg::CMD_MATCH: begin
                if (r_slot.valid && (r_slot.id == i_ctl.id)) begin
                    n_slot.valid = 1'b0;
                end
            end
            apq_pkg::CMD_PACK: begin
                // holes bubble towards the tail one place a cycle
                if (!r_slot.valid && i_next.valid) begin
                    n_slot = i_next;
                end else if (r_slot.valid && !i_prev.valid) begin
                    n_slot.valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_slot.key <= n_slot.key;
        r_slot.id  <= n_slot.id;
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
            r_ahead      <= 1'b0;
            r_eq         <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
            r_ahead      <= n_ahead;
            r_eq         <= n_eq;
        end
    end

    assign o_slot  = r_slot;
    assign o_ahead = r_ahead;
    assign o_eq    = r_eq;

endmodule

// ===== rtl/aging_priority_queue_top.sv =====
// Aging priority queue, kept sorted in a chain of cells (head = next to serve).
// Input stream (i_s_*): one word per request - insert, serve or remove.
// Output stream (o_m_*): one word per serve, and per insert dropped on a full
// queue; successful inserts and removes give no word.
// Config: i_cfg_we writes decay_rate; write only while the block is idle.
// Key of an insert = severity - decay_rate * arrival_time; highest key served
// first, ties to the smaller identifier.
// Steps per word, from acceptance back to ready:
//   serve  : pop the head into the output register, once it is free
//   insert : multiply, compare in every cell, shift into place
//   remove : clear the match, then compaction passes until no hole is left;
//            holes move one cell a cycle towards the tail.
// One request is in work at a time; o_s_tready is high only while idle.
// A result waits in the output register while the receiver stalls; the next
// request is still taken, and a later result holds its state until free.
// Reset (synchronous, active low) empties the queue and clears decay_rate;
// no clearing pass is needed.
module aging_priority_queue_top #(
    parameter int unsigned CAPACITY = apq_pkg::CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // operation, arrival_time, entry_id, severity, zero pad
    input  logic [apq_pkg::IN_W-1:0]    i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // status, served_id, zero pad
    output logic [apq_pkg::OUT_W-1:0]   o_m_tdata,
    input  logic                        i_cfg_we,
    input  logic [apq_pkg::RATE_W-1:0]  i_cfg_wdata
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_KEY   = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_INS   = 7'b0001000,
        S_SERVE = 7'b0010000,
        S_REM   = 7'b0100000,
        S_PACK  = 7'b1000000
    } t_state;

    t_state                         r_state;
    t_state                         n_state;
    logic [apq_pkg::RATE_W-1:0]     r_decay;
    logic [apq_pkg::TIME_W-1:0]     r_when;
    logic [apq_pkg::SEV_W-1:0]      r_sev;
    logic [apq_pkg::ID_W-1:0]       r_id;
    logic [apq_pkg::KEY_W-1:0]      r_key;
    logic [apq_pkg::KEY_W-1:0]      n_key;
    logic [apq_pkg::PROD_W-1:0]     w_prod;

    logic                           r_out_valid;
    logic [apq_pkg::STAT_W-1:0]     r_out_status;
    logic [apq_pkg::ID_W-1:0]       r_out_id;
    logic                           w_out_load;
    logic [apq_pkg::STAT_W-1:0]     w_out_status;
    logic [apq_pkg::ID_W-1:0]       w_out_id;
    logic                           w_out_free;

    apq_pkg::t_cell_ctl             w_ctl;
    apq_pkg::t_slot                 w_slot [CAPACITY];
    logic [CAPACITY-1:0]            w_ahead;
    logic [CAPACITY-1:0]            w_eq;
    logic [CAPACITY-1:0]            w_bubble;
    logic                           w_any_eq;
    logic                           w_any_bubble;
    logic                           w_full;
    logic                           w_accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    assign w_prod = apq_pkg::PROD_W'({{apq_pkg::TIME_W{1'b0}}, r_decay} *
                                     {{apq_pkg::RATE_W{1'b0}}, r_when});
    assign n_key  = apq_pkg::KEY_W'(r_sev) - apq_pkg::KEY_W'(w_prod);

    // cell chain
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            apq_pkg::t_slot w_prev;
            apq_pkg::t_slot w_next;
            logic           w_prev_ahead;

            if (g == 0) begin : g_head
                assign w_prev       = '{valid: 1'b1, key: '0, id: '0};
                assign w_prev_ahead = 1'b0;
            end else begin : g_body
                assign w_prev       = w_slot[g-1];
                assign w_prev_ahead = w_ahead[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_next       = '{valid: 1'b0, key: '0, id: '0};
                assign w_bubble[g]  = 1'b0;
            end else begin : g_link
                assign w_next       = w_slot[g+1];
                assign w_bubble[g]  = !w_slot[g].valid && w_slot[g+1].valid;
            end

            apq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_prev       (w_prev),
                .i_prev_ahead (w_prev_ahead),
                .i_next       (w_next),
                .o_slot       (w_slot[g]),
                .o_ahead      (w_ahead[g]),
                .o_eq         (w_eq[g])
            );
        end
    endgenerate

    assign w_any_eq     = |w_eq;
    assign w_any_bubble = |w_bubble;
    assign w_full       = w_slot[CAPACITY-1].valid;

    always_comb begin
        n_state      = r_state;
        w_ctl.cmd    = apq_pkg::CMD_NONE;
        w_ctl.key    = r_key;
        w_ctl.id     = r_id;
        w_out_load   = 1'b0;
        w_out_status = apq_pkg::ST_SERVED;
        w_out_id     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_s_tdata[1:0])
                        apq_pkg::OP_INSERT: n_state = S_KEY;
                        apq_pkg::OP_SERVE:  n_state = S_SERVE;
                        apq_pkg::OP_REMOVE: n_state = S_REM;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_KEY: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                w_ctl.cmd = apq_pkg::CMD_CMP;
                n_state   = S_INS;
            end
            S_INS: begin
                if (w_any_eq) begin
                    n_state = S_IDLE;
                end else if (w_full) begin
                    if (w_out_free) begin
                        w_out_load   = 1'b1;
                        w_out_status = apq_pkg::ST_FULL;
                        n_state      = S_IDLE;
                    end
                end else begin
                    w_ctl.cmd = apq_pkg::CMD_INS;
                    n_state   = S_IDLE;
                end
            end
            S_SERVE: begin
                if (w_out_free) begin
                    w_ctl.cmd  = apq_pkg::CMD_POP;
                    w_out_load = 1'b1;
                    if (w_slot[0].valid) begin
                        w_out_status = apq_pkg::ST_SERVED;
                        w_out_id     = w_slot[0].id;
                    end else begin
                        w_out_status = apq_pkg::ST_EMPTY;
                    end
                    n_state = S_IDLE;
                end
            end
            S_REM: begin
                w_ctl.cmd = apq_pkg::CMD_MATCH;
                n_state   = S_PACK;
            end
            S_PACK: begin
                if (w_any_bubble) begin
                    w_ctl.cmd = apq_pkg::CMD_PACK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_decay     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_decay <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_when <= i_s_tdata[21:2];
            r_id   <= i_s_tdata[85:22];
            r_sev  <= i_s_tdata[105:86];
        end
        if (r_state == S_KEY) begin
            r_key <= n_key;
        end
        if (w_out_load) begin
            r_out_status <= w_out_status;
            r_out_id     <= w_out_id;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(apq_pkg::OUT_W - apq_pkg::ID_W - apq_pkg::STAT_W){1'b0}},
                         r_out_id, r_out_status};

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_compact_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_any_bubble)
        else $error("hole in the cell chain while idle");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && w_slot[1].valid) |->
            apq_pkg::ahead_of(w_slot[0].key, w_slot[0].id, w_slot[1].key, w_slot[1].id))
        else $error("head cell not ahead of its neighbour");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_INS) && w_full && !w_any_eq && w_out_free) |=>
            (o_m_tvalid && (r_out_status == apq_pkg::ST_FULL)))
        else $error("insert on full queue did not report full");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> ((r_state == S_INS) || (r_state == S_SERVE)))
        else $error("result written outside insert or serve");
`endif

endmodule
